// File: sv/vpst_pkg.sv
// vpst_pkg: shared types, constants and state codes for the pore surface tracker
// no dependencies; imported by every module of the block except vpst_ram

package vpst_pkg;

    localparam int MAX_X_DEF = 64;
    localparam int MAX_Y_DEF = 64;
    localparam int MAX_Z_DEF = 64;

    localparam int POS_W   = 6;
    localparam int GRID_W  = 7;
    localparam int FACES_W = 21;
    localparam int PORES_W = 19;
    localparam int DEPTH_W = 25;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_GRID_X = 2'd0;
    localparam logic [1:0] REG_GRID_Y = 2'd1;
    localparam logic [1:0] REG_GRID_Z = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } pore_req_t;

    typedef struct packed {
        logic [FACES_W-1:0] face_count;
        logic [PORES_W-1:0] pore_total;
        logic [DEPTH_W-1:0] depth_total;
        logic               rejected;
    } pore_result_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SELF,
        ST_YM,
        ST_YP,
        ST_ZM,
        ST_ZP
    } vpst_state_t;

endpackage

// File: sv/vpst_ram.sv
// vpst_ram: generic single-port synchronous ram with registered read
// no dependencies

module vpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/voxel_pore_surface_tracker.sv
// voxel_pore_surface_tracker: occupancy bitmap, exposed face count and pore totals
// depends on vpst_pkg and vpst_ram
//
//  channel   | signals                               | handshake
//  ----------+---------------------------------------+------------------------------
//  request   | start, busy, req                      | taken when start && !busy
//  result    | done, result                          | one-cycle strobe, no stall
//  config    | psel penable pwrite paddr pwdata ...  | write in access phase, pready=1
//
// sequence: for a new pore inside the grid the accept cycle reads the self row, then
// states ST_SELF, ST_YM, ST_YP and ST_ZM read y-1, y+1, z-1, z+1 and ST_ZP writes back
// the self row; the single port of the occupancy ram forces these steps in turn.
// a duplicate ends in ST_SELF, a coordinate outside the grid in the accept cycle.
// the result strobe comes in the cycle after the last cycle of the request.
// reset: a clearing pass writes zero to all MAX_Y*MAX_Z rows (4096 by default)
// with busy high; configuration writes are taken during it.
// the result side cannot stall; a result register lets the next request enter
// while the previous result is on the ports.

module voxel_pore_surface_tracker #(
    parameter int MAX_X = vpst_pkg::MAX_X_DEF,
    parameter int MAX_Y = vpst_pkg::MAX_Y_DEF,
    parameter int MAX_Z = vpst_pkg::MAX_Z_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  vpst_pkg::pore_req_t           req,
    // result channel
    output logic                          done,
    output vpst_pkg::pore_result_t        result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vpst_pkg::PADDR_W-1:0]  paddr,
    input  logic [vpst_pkg::PDATA_W-1:0]  pwdata,
    output logic [vpst_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    import vpst_pkg::*;

    // one ram row holds all x cells of one (y, z) pair
    localparam int ROWS = MAX_Y * MAX_Z;
    localparam int AW   = $clog2(ROWS);
    localparam int GMAX = (1 << GRID_W) - 1;

    localparam logic [GRID_W-1:0] CAP_X = (MAX_X > GMAX) ? GRID_W'(GMAX) : GRID_W'(MAX_X);
    localparam logic [GRID_W-1:0] CAP_Y = (MAX_Y > GMAX) ? GRID_W'(GMAX) : GRID_W'(MAX_Y);
    localparam logic [GRID_W-1:0] CAP_Z = (MAX_Z > GMAX) ? GRID_W'(GMAX) : GRID_W'(MAX_Z);

    localparam logic [AW-1:0]      LAST_ROW = AW'(ROWS - 1);
    localparam logic [AW-1:0]      Y_STRIDE = AW'(MAX_Y);
    localparam logic [MAX_X-1:0]   ROW_ONE  = {{(MAX_X-1){1'b0}}, 1'b1};
    localparam logic [FACES_W+1:0] FACES_MAX = {2'b00, {FACES_W{1'b1}}};
    localparam logic [PORES_W-1:0] PORES_MAX = {PORES_W{1'b1}};
    localparam logic [DEPTH_W:0]   DEPTH_MAX = {1'b0, {DEPTH_W{1'b1}}};

    // ---------------------------------------------------------------- registers
    vpst_state_t        state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;

    logic [GRID_W-1:0]  grid_x_reg, grid_x_next;
    logic [GRID_W-1:0]  grid_y_reg, grid_y_next;
    logic [GRID_W-1:0]  grid_z_reg, grid_z_next;

    logic [FACES_W-1:0] faces_reg, faces_next;
    logic [PORES_W-1:0] pores_reg, pores_next;
    logic [DEPTH_W-1:0] dsum_reg, dsum_next;

    pore_req_t          pos_reg, pos_next;
    logic [AW-1:0]      self_addr_reg, self_addr_next;
    logic [MAX_X-1:0]   row_reg, row_next;
    logic [2:0]         nb_reg, nb_next;

    logic               done_reg, done_next;
    pore_result_t       result_reg, result_next;

    // ---------------------------------------------------------------- ram
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [MAX_X-1:0]   ram_wdata;
    logic [MAX_X-1:0]   ram_rdata;

    vpst_ram #(
        .WIDTH (MAX_X),
        .DEPTH (ROWS)
    ) u_occ_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- grid checks
    logic [GRID_W-1:0]  ext_x, ext_y, ext_z;
    logic               accept;
    logic               req_in_grid;
    logic [31:0]        req_lin;
    logic [AW-1:0]      req_addr;
    logic               in_xm, in_xp, in_ym, in_yp, in_zm, in_zp;

    // extents saturate at the grid size the memory was built for
    assign ext_x = (grid_x_reg > CAP_X) ? CAP_X : grid_x_reg;
    assign ext_y = (grid_y_reg > CAP_Y) ? CAP_Y : grid_y_reg;
    assign ext_z = (grid_z_reg > CAP_Z) ? CAP_Z : grid_z_reg;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign req_in_grid = ({1'b0, req.pos_x} < ext_x) &&
                         ({1'b0, req.pos_y} < ext_y) &&
                         ({1'b0, req.pos_z} < ext_z);

    // row address z*MAX_Y + y, fixed layout independent of the extents
    assign req_lin  = 32'(req.pos_z) * 32'(MAX_Y) + 32'(req.pos_y);
    assign req_addr = req_lin[AW-1:0];

    // neighbor lies inside the grid in use
    assign in_xm = (pos_reg.pos_x != '0);
    assign in_xp = (({1'b0, pos_reg.pos_x} + 7'd1) < ext_x);
    assign in_ym = (pos_reg.pos_y != '0);
    assign in_yp = (({1'b0, pos_reg.pos_y} + 7'd1) < ext_y);
    assign in_zm = (pos_reg.pos_z != '0);
    assign in_zp = (({1'b0, pos_reg.pos_z} + 7'd1) < ext_z);

    // bits picked out of the row just read
    logic [MAX_X-1:0]   sh_self, sh_xm, sh_xp;
    logic               occ_bit;

    assign sh_self = ram_rdata >> pos_reg.pos_x;
    assign sh_xm   = ram_rdata >> (pos_reg.pos_x - 6'd1);
    assign sh_xp   = ram_rdata >> ({1'b0, pos_reg.pos_x} + 7'd1);
    assign occ_bit = sh_self[0];

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && req_in_grid)
                begin
                    state_next = ST_SELF;
                end
            end
            ST_SELF:
            begin
                state_next = occ_bit ? ST_IDLE : ST_YM;
            end
            ST_YM:   state_next = ST_YP;
            ST_YP:   state_next = ST_ZM;
            ST_ZM:   state_next = ST_ZP;
            ST_ZP:   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- ram control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = row_reg;
        ram_addr  = self_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                ram_addr  = clr_reg;
            end
            ST_IDLE:
            begin
                ram_addr = req_addr;
            end
            // out-of-grid neighbors read the self row so the address stays in range
            ST_SELF: ram_addr = in_ym ? (self_addr_reg - AW'(1)) : self_addr_reg;
            ST_YM:   ram_addr = in_yp ? (self_addr_reg + AW'(1)) : self_addr_reg;
            ST_YP:   ram_addr = in_zm ? (self_addr_reg - Y_STRIDE) : self_addr_reg;
            ST_ZM:   ram_addr = in_zp ? (self_addr_reg + Y_STRIDE) : self_addr_reg;
            ST_ZP:
            begin
                ram_we    = 1'b1;
                ram_wdata = row_reg;
            end
            default: ram_addr = self_addr_reg;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    logic [2:0]         nb_final;
    logic [FACES_W+1:0] face_up, face_sub, face_new;
    logic [DEPTH_W:0]   dsum_sum;

    always_comb
    begin
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        self_addr_next = self_addr_reg;
        row_next       = row_reg;
        nb_next        = nb_reg;
        faces_next     = faces_reg;
        pores_next     = pores_reg;
        dsum_next      = dsum_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        // face update: +6, -2 per occupied neighbor, clamped at both ends
        nb_final = nb_reg + {2'b00, in_zp && occ_bit};
        face_up  = {2'b00, faces_reg} + (FACES_W+2)'(6);
        face_sub = {(FACES_W-2)'(0), nb_final, 1'b0};
        face_new = (face_up < face_sub) ? '0 : (face_up - face_sub);
        if (face_new > FACES_MAX)
        begin
            face_new = FACES_MAX;
        end
        dsum_sum = {1'b0, dsum_reg} + (DEPTH_W+1)'(pos_reg.pos_z) + (DEPTH_W+1)'(1);
        if (dsum_sum > DEPTH_MAX)
        begin
            dsum_sum = DEPTH_MAX;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    pos_next       = req;
                    self_addr_next = req_addr;
                    if (!req_in_grid)
                    begin
                        done_next   = 1'b1;
                        result_next = '{faces_reg, pores_reg, dsum_reg, 1'b1};
                    end
                end
            end
            ST_SELF:
            begin
                if (occ_bit)
                begin
                    // duplicate pore
                    done_next   = 1'b1;
                    result_next = '{faces_reg, pores_reg, dsum_reg, 1'b1};
                end
                row_next = ram_rdata | (ROW_ONE << pos_reg.pos_x);
                nb_next  = {2'b00, in_xm && sh_xm[0]} + {2'b00, in_xp && sh_xp[0]};
            end
            ST_YM: nb_next = nb_reg + {2'b00, in_ym && occ_bit};
            ST_YP: nb_next = nb_reg + {2'b00, in_yp && occ_bit};
            ST_ZM: nb_next = nb_reg + {2'b00, in_zm && occ_bit};
            ST_ZP:
            begin
                faces_next  = face_new[FACES_W-1:0];
                pores_next  = (pores_reg < PORES_MAX) ? (pores_reg + PORES_W'(1)) : pores_reg;
                dsum_next   = dsum_sum[DEPTH_W-1:0];
                done_next   = 1'b1;
                result_next = '{face_new[FACES_W-1:0],
                                (pores_reg < PORES_MAX) ? (pores_reg + PORES_W'(1))
                                                        : pores_reg,
                                dsum_sum[DEPTH_W-1:0],
                                1'b0};
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------- config port
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        grid_x_next = grid_x_reg;
        grid_y_next = grid_y_reg;
        grid_z_next = grid_z_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_GRID_X: grid_x_next = pwdata[GRID_W-1:0];
                REG_GRID_Y: grid_y_next = pwdata[GRID_W-1:0];
                REG_GRID_Z: grid_z_next = pwdata[GRID_W-1:0];
                default:    grid_x_next = grid_x_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_GRID_X: prdata = PDATA_W'(grid_x_reg);
            REG_GRID_Y: prdata = PDATA_W'(grid_y_reg);
            REG_GRID_Z: prdata = PDATA_W'(grid_z_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            grid_x_reg <= GRID_RESET;
            grid_y_reg <= GRID_RESET;
            grid_z_reg <= GRID_RESET;
            faces_reg  <= '0;
            pores_reg  <= '0;
            dsum_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            grid_x_reg <= grid_x_next;
            grid_y_reg <= grid_y_next;
            grid_z_reg <= grid_z_next;
            faces_reg  <= faces_next;
            pores_reg  <= pores_next;
            dsum_reg   <= dsum_next;
            done_reg   <= done_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        self_addr_reg <= self_addr_next;
        row_reg       <= row_next;
        nb_reg        <= nb_next;
        result_reg    <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: sv/vpst_checker.sv
// vpst_checker: port-level assertions for the pore surface tracker, plus its bind
// depends on vpst_pkg and voxel_pore_surface_tracker

module vpst_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   done,
    input vpst_pkg::pore_result_t result
);

    import vpst_pkg::*;

    // totals carried by the last result
    logic [FACES_W-1:0] last_faces_reg;
    logic [PORES_W-1:0] last_pores_reg;
    logic [DEPTH_W-1:0] last_dsum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_faces_reg <= '0;
            last_pores_reg <= '0;
            last_dsum_reg  <= '0;
        end
        else if (done)
        begin
            last_faces_reg <= result.face_count;
            last_pores_reg <= result.pore_total;
            last_dsum_reg  <= result.depth_total;
        end
    end

    // a request either keeps the block busy or answers at once
    a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request neither started work nor produced a result");

    // a result only follows a request or work in progress
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a request");

    // a rejected request leaves all totals untouched
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.rejected) |-> (result.face_count == last_faces_reg &&
                                       result.pore_total == last_pores_reg &&
                                       result.depth_total == last_dsum_reg))
        else $error("rejected request changed the totals");

    // an accepted pore never lowers the pore or depth totals
    a_accept_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.rejected) |-> (result.pore_total != '0 &&
                                        result.pore_total >= last_pores_reg &&
                                        result.depth_total > last_dsum_reg ||
                                        result.depth_total == {DEPTH_W{1'b1}}))
        else $error("new pore did not advance the totals");

endmodule

bind voxel_pore_surface_tracker vpst_checker u_vpst_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: bench/pore_totals_checker.sv
// pore_totals_checker: watches the request, result and register channels of the tracker,
// predicts face count, pore count and depth sum per request and compares results
// depends on vpst_pkg

module pore_totals_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  vpst_pkg::pore_req_t           req,
    input  logic                          done,
    input  vpst_pkg::pore_result_t        result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [vpst_pkg::PADDR_W-1:0]  paddr,
    input  logic [vpst_pkg::PDATA_W-1:0]  pwdata,
    input  logic [vpst_pkg::PDATA_W-1:0]  prdata,
    input  logic                          pready,
    output int                            mismatches,
    output int                            pending
);

    import vpst_pkg::*;

    localparam int CELLS     = MAX_X_DEF * MAX_Y_DEF * MAX_Z_DEF;
    localparam int FACES_TOP = (1 << FACES_W) - 1;
    localparam int PORES_TOP = (1 << PORES_W) - 1;
    localparam int DEPTH_TOP = (1 << DEPTH_W) - 1;

    // predicted block state
    bit                 pore_map [0:CELLS-1];
    int                 faces;
    int                 pores;
    int                 depth_sum;
    logic [GRID_W-1:0]  grid_x;
    logic [GRID_W-1:0]  grid_y;
    logic [GRID_W-1:0]  grid_z;

    pore_result_t       totals_q [$];

    initial
    begin
        faces      = 0;
        pores      = 0;
        depth_sum  = 0;
        grid_x     = GRID_RESET;
        grid_y     = GRID_RESET;
        grid_z     = GRID_RESET;
        mismatches = 0;
        pending    = 0;
    end

    // extent in use, saturated at the grid size
    function automatic int span(logic [GRID_W-1:0] g, int cap);
        return (g > cap) ? cap : int'(g);
    endfunction

    // pore present and inside the grid in use
    function automatic bit pore_at(int x, int y, int z, int ex, int ey, int ez);
        if (x < 0 || y < 0 || z < 0)
            return 1'b0;
        if (x >= ex || y >= ey || z >= ez)
            return 1'b0;
        return pore_map[(z * MAX_Y_DEF + y) * MAX_X_DEF + x];
    endfunction

    function automatic pore_result_t etch_voxel(pore_req_t r);
        int           ex;
        int           ey;
        int           ez;
        int           x;
        int           y;
        int           z;
        int           f;
        bit           rej;
        pore_result_t o;
        ex = span(grid_x, MAX_X_DEF);
        ey = span(grid_y, MAX_Y_DEF);
        ez = span(grid_z, MAX_Z_DEF);
        x  = r.pos_x;
        y  = r.pos_y;
        z  = r.pos_z;
        rej = (x >= ex) || (y >= ey) || (z >= ez) || pore_at(x, y, z, ex, ey, ez);
        if (!rej)
        begin
            f = faces + 6;
            if (pore_at(x - 1, y, z, ex, ey, ez)) f -= 2;
            if (pore_at(x + 1, y, z, ex, ey, ez)) f -= 2;
            if (pore_at(x, y - 1, z, ex, ey, ez)) f -= 2;
            if (pore_at(x, y + 1, z, ex, ey, ez)) f -= 2;
            if (pore_at(x, y, z - 1, ex, ey, ez)) f -= 2;
            if (pore_at(x, y, z + 1, ex, ey, ez)) f -= 2;
            if (f < 0) f = 0;
            if (f > FACES_TOP) f = FACES_TOP;
            faces = f;
            if (pores < PORES_TOP) pores++;
            depth_sum = (depth_sum + z + 1 > DEPTH_TOP) ? DEPTH_TOP : depth_sum + z + 1;
            pore_map[(z * MAX_Y_DEF + y) * MAX_X_DEF + x] = 1'b1;
        end
        o.face_count  = faces[FACES_W-1:0];
        o.pore_total  = pores[PORES_W-1:0];
        o.depth_total = depth_sum[DEPTH_W-1:0];
        o.rejected    = rej;
        return o;
    endfunction

    always @(posedge clk)
    begin : watch
        pore_result_t       want;
        logic [PDATA_W-1:0] reg_want;
        bit                 readable;
        if (rst_n)
        begin
            // result first, so a request taken at this edge queues behind it
            if (done)
            begin
                if (totals_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: got faces %0d pores %0d depth %0d rej %0b",
                                 result.face_count, result.pore_total,
                                 result.depth_total, result.rejected);
                    mismatches++;
                end
                else
                begin
                    want = totals_q.pop_front();
                    if (result.face_count !== want.face_count
                        || result.pore_total !== want.pore_total
                        || result.depth_total !== want.depth_total
                        || result.rejected !== want.rejected)
                    begin
                        if (mismatches < 10)
                        begin
                            $write("result mismatch: exp faces %0d pores %0d depth %0d rej %0b",
                                   want.face_count, want.pore_total, want.depth_total,
                                   want.rejected);
                            $display(" / got faces %0d pores %0d depth %0d rej %0b",
                                     result.face_count, result.pore_total,
                                     result.depth_total, result.rejected);
                        end
                        mismatches++;
                    end
                end
            end

            if (psel && penable && pready)
            begin
                readable = 1'b1;
                reg_want = '0;
                case (paddr[3:2])
                    REG_GRID_X:
                    begin
                        if (pwrite) grid_x = pwdata[GRID_W-1:0];
                        reg_want[GRID_W-1:0] = grid_x;
                    end
                    REG_GRID_Y:
                    begin
                        if (pwrite) grid_y = pwdata[GRID_W-1:0];
                        reg_want[GRID_W-1:0] = grid_y;
                    end
                    REG_GRID_Z:
                    begin
                        if (pwrite) grid_z = pwdata[GRID_W-1:0];
                        reg_want[GRID_W-1:0] = grid_z;
                    end
                    default:
                        readable = 1'b0;
                endcase
                if (!pwrite && readable && prdata !== reg_want)
                begin
                    if (mismatches < 10)
                        $display("register read mismatch at 0x%0h: exp 0x%0h got 0x%0h",
                                 paddr, reg_want, prdata);
                    mismatches++;
                end
            end

            if (start && !busy)
                totals_q.push_back(etch_voxel(req));

            pending = totals_q.size();
        end
    end

endmodule

// File: bench/testbench.sv
// testbench: top level for the pore surface tracker, makes requests and register
// traffic and gives the verdict; depends on vpst_pkg, pore_totals_checker and the block

module testbench;

    import vpst_pkg::*;

    // index past the last register, writes there must change nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    pore_req_t           req;
    logic                done;
    pore_result_t        result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  mismatches;
    int                  pending;

    // coordinates sent lately, used to build clusters of touching pores
    pore_req_t           recent_spots [$];

    voxel_pore_surface_tracker u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pore_totals_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #10 clk = ~clk;

    // hang guard: clearing pass plus every request with its longest gap, many times over
    initial
    begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // one request; called at a falling edge, returns at the falling edge after it was
    // taken with start still high so back-to-back requests keep it up
    task automatic issue_pore(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [POS_W-1:0] z);
        start     = 1'b1;
        req.pos_x = x;
        req.pos_y = y;
        req.pos_z = z;
        // busy is stable mid-cycle, so a low value here means the next edge takes it
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    // apb setup then access phase; pready is checked before the completing edge
    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        while (!pready)
            @(negedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // new extents, only once every request has its result back
    task automatic set_grid(input logic [GRID_W-1:0] gx, input logic [GRID_W-1:0] gy,
                            input logic [GRID_W-1:0] gz);
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        // junk in the upper data bits must be dropped by the register
        apb_access(REG_GRID_X, 1'b1, {$urandom_range(0, 1) ? 25'h1ffffff : 25'h0, gx});
        apb_access(REG_GRID_Y, 1'b1, {25'h0, gy});
        apb_access(REG_GRID_Z, 1'b1, {25'($urandom()), gz});
        if ($urandom_range(0, 3) == 0)
            apb_access(REG_UNUSED, 1'b1, $urandom());
        apb_access(REG_GRID_X, 1'b0, '0);
        apb_access(REG_GRID_Y, 1'b0, '0);
        apb_access(REG_GRID_Z, 1'b0, '0);
    endtask

    // mostly small grids so pores crowd and touch, now and then the full or a wild extent
    function automatic logic [GRID_W-1:0] pick_extent();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return GRID_W'($urandom_range(0, 127));
        if (r == 1)
            return 7'd64;
        return GRID_W'($urandom_range(1, 6));
    endfunction

    // next coordinate: neighbour of a recent one, a point inside the grid,
    // a repeat, or anything at all
    function automatic pore_req_t next_spot(logic [GRID_W-1:0] gx, logic [GRID_W-1:0] gy,
                                            logic [GRID_W-1:0] gz);
        pore_req_t s;
        int        mode;
        int        ex;
        int        ey;
        int        ez;
        int        axis;
        logic [POS_W-1:0] step;
        ex   = (gx > 64) ? 64 : gx;
        ey   = (gy > 64) ? 64 : gy;
        ez   = (gz > 64) ? 64 : gz;
        mode = $urandom_range(0, 9);
        if (mode < 6 && recent_spots.size() != 0)
        begin
            s    = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
            axis = $urandom_range(0, 2);
            // step of -1 wraps to 63, which lands outside any smaller grid
            step = $urandom_range(0, 1) ? 6'd1 : 6'h3f;
            if (axis == 0)
                s.pos_x = s.pos_x + step;
            else if (axis == 1)
                s.pos_y = s.pos_y + step;
            else
                s.pos_z = s.pos_z + step;
        end
        else if (mode < 8 && ex != 0 && ey != 0 && ez != 0)
        begin
            s.pos_x = POS_W'($urandom_range(0, ex - 1));
            s.pos_y = POS_W'($urandom_range(0, ey - 1));
            s.pos_z = POS_W'($urandom_range(0, ez - 1));
        end
        else if (mode == 8 && recent_spots.size() != 0)
            s = recent_spots[$urandom_range(0, recent_spots.size() - 1)];
        else
        begin
            s.pos_x = POS_W'($urandom_range(0, 63));
            s.pos_y = POS_W'($urandom_range(0, 63));
            s.pos_z = POS_W'($urandom_range(0, 63));
        end
        recent_spots.push_back(s);
        if (recent_spots.size() > 64)
            void'(recent_spots.pop_front());
        return s;
    endfunction

    initial
    begin : stimulus
        logic [GRID_W-1:0] gx;
        logic [GRID_W-1:0] gy;
        logic [GRID_W-1:0] gz;
        pore_req_t         s;
        bit                gaps_on;
        clk     = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        req     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: full grid, corners, single neighbours, a fully enclosed voxel
        // and a repeat; requests wait out the clearing pass on busy
        set_grid(7'd64, 7'd64, 7'd64);
        issue_pore(6'd0, 6'd0, 6'd0);
        issue_pore(6'd63, 6'd63, 6'd63);
        issue_pore(6'd0, 6'd0, 6'd0);
        issue_pore(6'd1, 6'd0, 6'd0);
        issue_pore(6'd0, 6'd1, 6'd0);
        issue_pore(6'd0, 6'd0, 6'd1);
        issue_pore(6'd62, 6'd63, 6'd63);
        issue_pore(6'd63, 6'd62, 6'd63);
        issue_pore(6'd63, 6'd63, 6'd62);
        issue_pore(6'd1, 6'd5, 6'd5);
        issue_pore(6'd9, 6'd10, 6'd10);
        issue_pore(6'd11, 6'd10, 6'd10);
        issue_pore(6'd10, 6'd9, 6'd10);
        issue_pore(6'd10, 6'd11, 6'd10);
        issue_pore(6'd10, 6'd10, 6'd9);
        issue_pore(6'd10, 6'd10, 6'd11);
        issue_pore(6'd10, 6'd10, 6'd10);

        // extents above the grid size saturate: the far corner is still a repeat
        set_grid(7'd127, 7'd127, 7'd127);
        issue_pore(6'd63, 6'd63, 6'd63);
        issue_pore(6'd32, 6'd32, 6'd32);

        // zero extent rejects everything, even a known pore
        set_grid(7'd0, 7'd0, 7'd0);
        issue_pore(6'd0, 6'd0, 6'd0);
        issue_pore(6'd5, 6'd5, 6'd5);

        // shrunk grid: a pore past the x extent is neither a repeat nor a neighbour
        set_grid(7'd1, 7'd64, 7'd64);
        apb_access(REG_UNUSED, 1'b1, 32'hffff_ffff);
        issue_pore(6'd1, 6'd0, 6'd0);
        issue_pore(6'd0, 6'd5, 6'd5);

        // random phases, each with its own extents; occupancy carries over so
        // grids that grow again meet old pores at and beyond their edges
        for (int ph = 0; ph < 12; ph++)
        begin
            gx = pick_extent();
            gy = pick_extent();
            gz = pick_extent();
            set_grid(gx, gy, gz);
            // the last phase runs with no gaps at all, some others too
            gaps_on = (ph != 11) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 155; k++)
            begin
                if (gaps_on && $urandom_range(0, 3) == 0)
                begin
                    start = 1'b0;
                    repeat ($urandom_range(1, 19)) @(negedge clk);
                end
                s = next_spot(gx, gy, gz);
                issue_pore(s.pos_x, s.pos_y, s.pos_z);
            end
        end

        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        // let any stray strobe show up
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
